[rtl/api_frame_deframer_unit_macros.svh]
// Assertion macros shared by the frame receiver modules.
`ifndef API_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define API_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AFD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Check that cons holds in the cycle after ante.
`define AFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver sequence check failed");

`endif

[rtl/afd_pkg.sv]
// Shared widths, codes and types of the frame receiver.
package afd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

    localparam logic [BYTE_W-1:0] GOOD_SUM = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd126;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 16'd100;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  frame_length;
    } afd_result_t;

endpackage

[rtl/afd_ifs.sv]
// Valid/ready channel interfaces for received bytes and frame results.
interface afd_in_if
    import afd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface afd_out_if
    import afd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output frame_length, input ready);
    modport sink (input valid, input kind, input data_byte, input byte_index,
                  input frame_length, output ready);
endinterface

[rtl/api_frame_deframer_unit.sv]
// Top level of the length and checksum frame receiver.
//
// Receives one serial byte per request on rx_chan and hunts for the start
// byte, reads a big-endian 16-bit payload length, streams each payload byte
// out on res_chan with its index and the declared length, and closes the
// frame with a good or bad checksum result (good when the byte sum of payload
// plus checksum is 0xFF modulo 256). A length above max_length drops the
// frame with no result; a zero length goes straight to the checksum byte.
// Throughput is one byte per clock while res_chan is not blocked: the byte goes
// into an input register, one pass of frame logic updates the state and fills
// the result register, so a result is offered once its byte has passed from
// the input register into the result register. Bytes that produce no result
// (hunt, length) never wait on res_chan; a payload or checksum byte waits in
// the input register only while the result register is full and not being
// taken. Write start_byte (index 0) and max_length (index 1) through
// cfg_we/cfg_index/cfg_wdata while the block is idle.
module api_frame_deframer_unit
    import afd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    afd_in_if.sink                rx_chan,
    afd_out_if.source             res_chan,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "api_frame_deframer_unit_macros.svh"

    // configuration registers
    logic [BYTE_W-1:0] start_byte_reg;
    logic [LEN_W-1:0]  max_length_reg;

    // input register to frame logic
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              advance;

    // frame logic to result register
    logic              has_result;
    afd_result_t       result;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    afd_result_t       out_reg;
    logic              out_free;
    logic              out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_BYTE: start_byte_reg <= cfg_wdata[BYTE_W-1:0];
                REG_MAX_LENGTH: max_length_reg <= cfg_wdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    afd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx_chan.valid),
        .in_ready   (rx_chan.ready),
        .in_byte    (rx_chan.rx_byte),
        .take       (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    afd_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .rx_byte    (held_byte),
        .start_byte (start_byte_reg),
        .max_length (max_length_reg),
        .has_result (has_result),
        .result     (result)
    );

    // Advance the held byte unless it makes a result and the result slot is blocked.
    assign out_free       = !out_valid_reg || res_chan.ready;
    assign advance        = held_valid && (!has_result || out_free);
    assign out_load       = advance && has_result;
    assign out_valid_next = out_load ? 1'b1 : (res_chan.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until it is taken; load only into a free slot.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign res_chan.valid        = out_valid_reg;
    assign res_chan.kind         = out_reg.kind;
    assign res_chan.data_byte    = out_reg.data_byte;
    assign res_chan.byte_index   = out_reg.byte_index;
    assign res_chan.frame_length = out_reg.frame_length;

    `AFD_ASSERT_IMPLY(a_end_fields_zero, out_valid_reg && out_reg.kind != KIND_DATA,
        out_reg.data_byte == '0 && out_reg.byte_index == '0)
    `AFD_ASSERT_IMPLY(a_index_below_len, out_valid_reg && out_reg.kind == KIND_DATA,
        out_reg.byte_index < out_reg.frame_length)
    `AFD_ASSERT_IMPLY(a_no_overwrite, out_load, out_free)

endmodule

[rtl/afd_in_stage.sv]
// Input register: holds one received byte until the frame logic takes it.
module afd_in_stage
    import afd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              take,
    output logic              held_valid,
    output logic [BYTE_W-1:0] held_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              load;

    assign in_ready   = !valid_reg || take;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

[rtl/afd_fsm.sv]
// Frame state machine: phase, length, payload count and running checksum.
module afd_fsm
    import afd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] start_byte,
    input  logic [LEN_W-1:0]  max_length,
    output logic              has_result,
    output afd_result_t       result
);

`include "api_frame_deframer_unit_macros.svh"

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  cnt_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;

    logic [LEN_W-1:0]  full_len;
    logic [LEN_W-1:0]  cnt_inc;
    logic [BYTE_W-1:0] sum_add;

    assign full_len = {len_reg[LEN_W-1:BYTE_W], rx_byte};
    assign cnt_inc  = cnt_reg + LEN_W'(1);
    assign sum_add  = sum_reg + rx_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        has_result  = 1'b0;
        result      = '0;
        case (phase_reg)
            PH_LEN_HI:
            begin
                len_next   = {rx_byte, {BYTE_W{1'b0}}};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                cnt_next = '0;
                sum_next = '0;
                if (full_len > max_length)
                begin
                    len_next   = '0;
                    phase_next = PH_HUNT;
                end
                else if (full_len == '0)
                begin
                    len_next   = full_len;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    len_next   = full_len;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                has_result          = 1'b1;
                result.kind         = KIND_DATA;
                result.data_byte    = rx_byte;
                result.byte_index   = cnt_reg;
                result.frame_length = len_reg;
                cnt_next            = cnt_inc;
                sum_next            = sum_add;
                if (cnt_inc >= len_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                has_result          = 1'b1;
                result.kind         = (sum_add == GOOD_SUM) ? KIND_GOOD : KIND_BAD;
                result.frame_length = len_reg;
                phase_next          = PH_HUNT;
                len_next            = '0;
                cnt_next            = '0;
                sum_next            = '0;
            end
            default:
            begin
                // hunt, and any stray phase code acts as hunt with counters cleared
                if (phase_reg != PH_HUNT)
                begin
                    len_next = '0;
                    cnt_next = '0;
                    sum_next = '0;
                end
                phase_next = (rx_byte == start_byte) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    `AFD_ASSERT_IMPLY(a_payload_in_range, phase_reg == PH_PAYLOAD,
        len_reg != '0 && cnt_reg < len_reg)
    `AFD_ASSERT_NEXT(a_frame_end_clears, advance && phase_reg == PH_CHECK,
        phase_reg == PH_HUNT && cnt_reg == '0 && sum_reg == '0)
    `AFD_ASSERT_IMPLY(a_count_idle_zero, phase_reg == PH_LEN_HI || phase_reg == PH_LEN_LO,
        cnt_reg == '0)

endmodule
